@@ rtl/pfsc_pkg.sv @@
// Shared constants and the run descriptor for the packet framer.
// No dependencies; used by pfsc_ctrl, pfsc_emit and the top level.
`default_nettype none

package pfsc_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 12;

    localparam int DEF_PAYLOAD_BYTES = 15;
    localparam int DEF_PACKET_BYTES  = 20;

    localparam logic [BYTE_W-1:0] HDR_MARK = 8'hAF;

    // Fixed byte positions at the head of every packet.
    localparam int POS_MARK  = 0;
    localparam int POS_TOTAL = 1;
    localparam int POS_CMD   = 2;
    localparam int POS_FNUM  = 3;
    localparam int HDR_BYTES = 4;
    // Header plus the closing checksum byte.
    localparam int OVERHEAD  = 5;

    // Byte values that one input beat needs to emit its run of packet bytes.
    typedef struct packed {
        logic [BYTE_W-1:0] frame_total;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] frame_num;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] checksum;
        logic              end_msg;
    } pfsc_desc_t;

endpackage

`default_nettype wire

@@ rtl/packet_framer_sum_checksum.sv @@
// Top level of the fixed-length packet framer with additive checksum.
// Depends on pfsc_pkg, pfsc_ctrl and pfsc_emit.
//
// Usage:
//   The item channel (item_valid/item_ready) carries one message byte per beat,
//   with command_code and message_length; those two are latched on the first
//   beat of a message and ignored afterwards. Length 0 counts as 1, and lengths
//   over 255 payload areas saturate so the frame count fits a byte.
//   The result channel (result_valid/result_ready) carries packet bytes:
//   0xAF, frame count, command, frame number, payload, zero pad, checksum.
//   end_of_packet flags each checksum byte, end_of_message the last one, and
//   last_of_run the final result beat caused by a given input beat.
//   The first result of an input beat is valid in the cycle after the beat is
//   accepted. Each input beat produces 1, 5 or up to PACKET_BYTES results,
//   one per cycle while result_ready is high; the run register takes the next
//   input beat in the same cycle its last result leaves, so throughput is set
//   by the one-byte-per-cycle result port.
//   A stall on result_ready holds the current byte and holds off item_ready.
//   Reset clears all frame state and drops any run in progress.
`default_nettype none

module packet_framer_sum_checksum #(
    parameter int PAYLOAD_BYTES = pfsc_pkg::DEF_PAYLOAD_BYTES,
    parameter int PACKET_BYTES  = pfsc_pkg::DEF_PACKET_BYTES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire logic [pfsc_pkg::BYTE_W-1:0]   data_byte,
    input  wire logic [pfsc_pkg::BYTE_W-1:0]   command_code,
    input  wire logic [pfsc_pkg::LEN_W-1:0]    message_length,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic [pfsc_pkg::BYTE_W-1:0]        packet_byte,
    output logic                               end_of_packet,
    output logic                               end_of_message,
    output logic                               last_of_run
);

    // Packet positions fit in this many bits.
    localparam int PosW = $clog2(PACKET_BYTES);

    pfsc_pkg::pfsc_desc_t desc;
    logic [PosW-1:0]      first_pos, data_pos, last_pos;
    logic                 load;
    logic                 free;

    // Advance frame state and load the run register on every accepted beat.
    assign item_ready = free;
    assign load       = item_valid && free;

    pfsc_ctrl #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .PACKET_BYTES  (PACKET_BYTES),
        .PosW          (PosW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .data_byte      (data_byte),
        .command_code   (command_code),
        .message_length (message_length),
        .desc           (desc),
        .first_pos      (first_pos),
        .data_pos       (data_pos),
        .last_pos       (last_pos)
    );

    pfsc_emit #(
        .PACKET_BYTES (PACKET_BYTES),
        .PosW         (PosW)
    ) u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .desc           (desc),
        .first_pos      (first_pos),
        .data_pos       (data_pos),
        .last_pos       (last_pos),
        .free           (free),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .packet_byte    (packet_byte),
        .end_of_packet  (end_of_packet),
        .end_of_message (end_of_message),
        .last_of_run    (last_of_run)
    );

endmodule

`default_nettype wire

@@ rtl/pfsc_ctrl.sv @@
// Message/frame bookkeeping: latches length and command, tracks slot and sum,
// and builds the run descriptor for each accepted beat. Uses pfsc_pkg.
`default_nettype none

module pfsc_ctrl #(
    parameter int PAYLOAD_BYTES = pfsc_pkg::DEF_PAYLOAD_BYTES,
    parameter int PACKET_BYTES  = pfsc_pkg::DEF_PACKET_BYTES,
    parameter int PosW          = $clog2(PACKET_BYTES)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire logic [pfsc_pkg::BYTE_W-1:0]   data_byte,
    input  wire logic [pfsc_pkg::BYTE_W-1:0]   command_code,
    input  wire logic [pfsc_pkg::LEN_W-1:0]    message_length,
    output pfsc_pkg::pfsc_desc_t               desc,
    output logic [PosW-1:0]                    first_pos,
    output logic [PosW-1:0]                    data_pos,
    output logic [PosW-1:0]                    last_pos
);

    localparam int Area   = PACKET_BYTES - pfsc_pkg::OVERHEAD;
    localparam int Fill   = (PAYLOAD_BYTES < Area) ? PAYLOAD_BYTES : Area;
    localparam int MaxLen = 255 * Fill;
    localparam int SlotW  = $clog2(Fill + 1);
    localparam int LenW   = pfsc_pkg::LEN_W;
    localparam int BW     = pfsc_pkg::BYTE_W;
    // Frame count = ceil(len / Fill) by reciprocal multiply, exact for XW-bit numerators.
    localparam int XW     = LenW + 1;
    localparam int Shift  = XW + $clog2(Fill);
    localparam int RW     = Shift + 1;
    localparam int Recip  = ((1 << Shift) + Fill - 1) / Fill;
    localparam int PW     = XW + RW;

    logic [LenW-1:0]  bytes_taken_reg, bytes_taken_next;
    logic [SlotW-1:0] slot_reg, slot_next;
    logic [BW-1:0]    frame_counter_reg, frame_counter_next;
    logic [BW-1:0]    frame_total_reg, frame_total_next;
    logic [BW-1:0]    running_sum_reg, running_sum_next;
    logic [BW-1:0]    held_command_reg, held_command_next;
    logic [LenW-1:0]  held_length_reg, held_length_next;

    logic             first;
    logic [LenW-1:0]  len_clamp;
    logic [XW-1:0]    ceil_num;
    logic [PW-1:0]    prod;
    logic [BW-1:0]    total_calc;
    logic [LenW-1:0]  len_sel;
    logic [BW-1:0]    cmd_sel, tot_sel, fnum_sel, sum_sel, sum_base, sum_new;
    logic [SlotW-1:0] slot_sel, slot_inc;
    logic [LenW-1:0]  taken_inc;
    logic             hdr, last, close;

    always_comb
    begin
        len_clamp = message_length;
        if (message_length == '0)
        begin
            len_clamp = LenW'(1);
        end
        else if (32'(message_length) > MaxLen)
        begin
            len_clamp = LenW'(MaxLen);
        end
    end

    assign ceil_num   = XW'(len_clamp) + XW'(Fill - 1);
    assign prod       = PW'(ceil_num) * PW'(Recip);
    assign total_calc = prod[Shift +: BW];

    assign first    = (bytes_taken_reg == '0);
    assign len_sel  = first ? len_clamp    : held_length_reg;
    assign cmd_sel  = first ? command_code : held_command_reg;
    assign tot_sel  = first ? total_calc   : frame_total_reg;
    assign fnum_sel = first ? BW'(1)       : frame_counter_reg;
    assign slot_sel = first ? '0           : slot_reg;
    assign sum_sel  = first ? '0           : running_sum_reg;

    // Restart the sum with the header on the first slot of a frame.
    assign hdr      = (slot_sel == '0);
    assign sum_base = hdr ? (pfsc_pkg::HDR_MARK + tot_sel + cmd_sel + fnum_sel) : sum_sel;
    assign sum_new  = sum_base + data_byte;

    assign taken_inc = bytes_taken_reg + LenW'(1);
    assign last      = (taken_inc >= len_sel);
    assign slot_inc  = slot_sel + SlotW'(1);
    assign close     = (slot_inc == SlotW'(Fill)) || last;

    always_comb
    begin
        bytes_taken_next   = bytes_taken_reg;
        slot_next          = slot_reg;
        frame_counter_next = frame_counter_reg;
        frame_total_next   = frame_total_reg;
        running_sum_next   = running_sum_reg;
        held_command_next  = held_command_reg;
        held_length_next   = held_length_reg;
        if (load)
        begin
            held_command_next  = cmd_sel;
            held_length_next   = len_sel;
            frame_total_next   = tot_sel;
            bytes_taken_next   = last ? '0 : taken_inc;
            slot_next          = close ? '0 : slot_inc;
            running_sum_next   = close ? '0 : sum_new;
            frame_counter_next = !close ? fnum_sel : (last ? BW'(1) : fnum_sel + BW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_taken_reg   <= '0;
            slot_reg          <= '0;
            frame_counter_reg <= BW'(1);
            frame_total_reg   <= '0;
            running_sum_reg   <= '0;
            held_command_reg  <= '0;
            held_length_reg   <= '0;
        end
        else
        begin
            bytes_taken_reg   <= bytes_taken_next;
            slot_reg          <= slot_next;
            frame_counter_reg <= frame_counter_next;
            frame_total_reg   <= frame_total_next;
            running_sum_reg   <= running_sum_next;
            held_command_reg  <= held_command_next;
            held_length_reg   <= held_length_next;
        end
    end

    // Padding adds nothing, so the checksum is the sum through this byte.
    assign desc.frame_total = tot_sel;
    assign desc.command     = cmd_sel;
    assign desc.frame_num   = fnum_sel;
    assign desc.data        = data_byte;
    assign desc.checksum    = sum_new;
    assign desc.end_msg     = last;

    assign data_pos  = PosW'(pfsc_pkg::HDR_BYTES) + PosW'(slot_sel);
    assign first_pos = hdr ? PosW'(pfsc_pkg::POS_MARK) : data_pos;
    assign last_pos  = close ? PosW'(PACKET_BYTES - 1) : data_pos;

endmodule

`default_nettype wire

@@ rtl/pfsc_emit.sv @@
// Run register and byte sequencer: holds one beat's descriptor and walks the
// packet positions it covers, one result beat per ready cycle. Uses pfsc_pkg.
`default_nettype none

module pfsc_emit #(
    parameter int PACKET_BYTES = pfsc_pkg::DEF_PACKET_BYTES,
    parameter int PosW         = $clog2(PACKET_BYTES)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire pfsc_pkg::pfsc_desc_t        desc,
    input  wire logic [PosW-1:0]             first_pos,
    input  wire logic [PosW-1:0]             data_pos,
    input  wire logic [PosW-1:0]             last_pos,
    output logic                             free,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output logic [pfsc_pkg::BYTE_W-1:0]      packet_byte,
    output logic                             end_of_packet,
    output logic                             end_of_message,
    output logic                             last_of_run
);

    localparam logic [PosW-1:0] PosCheck = PosW'(PACKET_BYTES - 1);

    logic                 valid_reg, valid_next;
    logic [PosW-1:0]      pos_reg, pos_next;
    logic [PosW-1:0]      data_pos_reg, last_pos_reg;
    pfsc_pkg::pfsc_desc_t desc_reg;
    logic                 fire, at_last;

    assign fire    = valid_reg && result_ready;
    assign at_last = (pos_reg == last_pos_reg);
    // Take a new beat when empty or when the final byte of this run leaves now.
    assign free    = !valid_reg || (result_ready && at_last);

    always_comb
    begin
        valid_next = valid_reg;
        pos_next   = pos_reg;
        if (load)
        begin
            valid_next = 1'b1;
            pos_next   = first_pos;
        end
        else if (fire)
        begin
            if (at_last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + PosW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            desc_reg     <= desc;
            data_pos_reg <= data_pos;
            last_pos_reg <= last_pos;
        end
    end

    always_comb
    begin
        case (32'(pos_reg))
            pfsc_pkg::POS_MARK:  packet_byte = pfsc_pkg::HDR_MARK;
            pfsc_pkg::POS_TOTAL: packet_byte = desc_reg.frame_total;
            pfsc_pkg::POS_CMD:   packet_byte = desc_reg.command;
            pfsc_pkg::POS_FNUM:  packet_byte = desc_reg.frame_num;
            default:
            begin
                if (pos_reg == data_pos_reg)
                begin
                    packet_byte = desc_reg.data;
                end
                else if (pos_reg == PosCheck)
                begin
                    packet_byte = desc_reg.checksum;
                end
                else
                begin
                    packet_byte = '0;
                end
            end
        endcase
    end

    assign result_valid   = valid_reg;
    assign end_of_packet  = (pos_reg == PosCheck);
    assign end_of_message = end_of_packet && desc_reg.end_msg;
    assign last_of_run    = at_last;

    a_free_only_at_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && free) |-> (result_ready && last_of_run))
        else $error("new beat taken while run still has bytes");

    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !at_last && !load) |=> (pos_reg == $past(pos_reg) + PosW'(1)))
        else $error("position did not advance after a result beat");

    a_pos_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (pos_reg <= last_pos_reg))
        else $error("position ran past end of run");

    a_eom_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && end_of_message) |-> (end_of_packet && last_of_run))
        else $error("end of message not on the closing checksum");

endmodule

`default_nettype wire
